// ===== rtl/core/ctb_pkg.sv =====
// Shared types and constants for the cassette tape bit encoder.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package ctb_pkg;

  localparam int unsigned SAMPLE_RATE = 44100;
  localparam int unsigned LEADER_HZ   = 770;
  localparam int unsigned SYNC_HZ     = 2200;
  localparam int unsigned ONE_HZ      = 1000;
  localparam int unsigned ZERO_HZ     = 2000;
  localparam int unsigned END_HZ      = 200;

  localparam logic [15:0] LEADER_HALF = 16'(SAMPLE_RATE / (2 * LEADER_HZ));
  localparam logic [15:0] SYNC_HALF   = 16'(SAMPLE_RATE / (2 * SYNC_HZ));
  localparam logic [15:0] ONE_HALF    = 16'(SAMPLE_RATE / (2 * ONE_HZ));
  localparam logic [15:0] ZERO_HALF   = 16'(SAMPLE_RATE / (2 * ZERO_HZ));
  localparam logic [15:0] END_HALF    = 16'(SAMPLE_RATE / (2 * END_HZ));

  localparam logic [15:0] SILENCE_RESET = 16'd15000;
  localparam logic [7:0]  CHK_INIT      = 8'hFF;

  localparam logic [9:0] DRIFT_LIMIT = 10'd800;
  localparam logic [9:0] DRIFT_ONE   = 10'd2;
  localparam logic [9:0] DRIFT_ZERO  = 10'd1;

  localparam logic [7:0] VAL_HIGH    = 8'd1;
  localparam logic [7:0] VAL_LOW     = 8'd255;
  localparam logic [7:0] VAL_SILENCE = 8'd0;

  typedef enum logic [2:0] {
    FUNC_LEADER   = 3'd0,
    FUNC_SYNC     = 3'd1,
    FUNC_DATA     = 3'd2,
    FUNC_CHECKSUM = 3'd3,
    FUNC_END      = 3'd4,
    FUNC_SILENCE  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_PERIOD,
    KIND_BYTE,
    KIND_SILENCE
  } kind_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  sample_value;
    logic [15:0] run_length;
    logic        last_of_run;
  } out_item_t;

  // one queued job for the back end
  typedef struct packed {
    kind_t       kind;
    logic        clr_drift;
    logic        use_drift;
    logic [7:0]  byte_val;
    logic [15:0] len;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctb_front.sv =====
// Front end: accepts items, keeps the running checksum and the silence
// register, and turns each item with a used func code into a job for the queue. Uses ctb_pkg.
`default_nettype none

module ctb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ctb_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire ctb_pkg::q_stat_t  q_stat,
  output logic                   q_push,
  output ctb_pkg::job_t          q_job
);

  logic [7:0]  chk_r, chk_nxt;
  logic [15:0] silence_r;
  logic        accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    chk_nxt         = chk_r;
    q_push          = 1'b0;
    q_job.kind      = ctb_pkg::KIND_PERIOD;
    q_job.clr_drift = 1'b0;
    q_job.use_drift = 1'b0;
    q_job.byte_val  = in_data.data_byte;
    q_job.len       = ctb_pkg::SYNC_HALF;
    case (in_data.func)
      ctb_pkg::FUNC_LEADER: begin
        q_push          = accept;
        q_job.clr_drift = 1'b1;
        q_job.len       = ctb_pkg::LEADER_HALF;
        if (accept) chk_nxt = ctb_pkg::CHK_INIT;
      end
      ctb_pkg::FUNC_SYNC: begin
        q_push    = accept;
        q_job.len = ctb_pkg::SYNC_HALF;
      end
      ctb_pkg::FUNC_DATA: begin
        q_push          = accept;
        q_job.kind      = ctb_pkg::KIND_BYTE;
        q_job.use_drift = 1'b1;
        if (accept) chk_nxt = chk_r ^ in_data.data_byte;
      end
      ctb_pkg::FUNC_CHECKSUM: begin
        // private drift from zero never reaches an extra sample in 8 bits
        q_push         = accept;
        q_job.kind     = ctb_pkg::KIND_BYTE;
        q_job.byte_val = chk_r;
      end
      ctb_pkg::FUNC_END: begin
        q_push    = accept;
        q_job.len = ctb_pkg::END_HALF;
      end
      ctb_pkg::FUNC_SILENCE: begin
        q_push     = accept;
        q_job.kind = ctb_pkg::KIND_SILENCE;
        q_job.len  = silence_r;
      end
      default: begin
        // unused codes are taken and dropped
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r     <= ctb_pkg::CHK_INIT;
      silence_r <= ctb_pkg::SILENCE_RESET;
    end else begin
      chk_r <= chk_nxt;
      if (cfg_we) silence_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctb_queue.sv =====
// Small register FIFO of jobs between front and back end.
// Uses ctb_pkg for the job and status types.
`default_nettype none

module ctb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ctb_pkg::job_t    push_job,
  input  wire logic             pop,
  output ctb_pkg::job_t         head_job,
  output ctb_pkg::q_stat_t      stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctb_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctb_back.sv =====
// Back end: walks one job at a time, keeps the drift accumulator and
// emits one run per cycle into the output register while out_stall is low. Uses ctb_pkg.
`default_nettype none

module ctb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctb_pkg::job_t      head_job,
  input  wire ctb_pkg::q_stat_t   q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ctb_pkg::out_item_t      out_data
);

  logic               act_r, act_nxt;
  ctb_pkg::job_t      job_r, job_nxt;
  logic               phase_r, phase_nxt;   // 0 high half, 1 low half
  logic [2:0]         bit_r, bit_nxt;
  logic [15:0]        half_r, half_nxt;
  logic [9:0]         drift_r, drift_nxt;
  logic               out_valid_r, out_valid_nxt;
  ctb_pkg::out_item_t out_r, out_nxt;

  logic               can_emit, emit, done;
  logic               cur_bit;
  logic [9:0]         drift_sum;
  logic               extra;
  logic [15:0]        bit_half;
  ctb_pkg::out_item_t res;

  assign can_emit = !out_valid_r || !out_stall;
  assign emit     = act_r && can_emit;
  assign done     = emit && res.last_of_run;
  assign q_pop    = !q_stat.empty && (!act_r || done);

  assign cur_bit   = job_r.byte_val[7];
  assign drift_sum = drift_r + (cur_bit ? ctb_pkg::DRIFT_ONE : ctb_pkg::DRIFT_ZERO);
  assign extra     = job_r.use_drift && (drift_sum > ctb_pkg::DRIFT_LIMIT);
  assign bit_half  = (cur_bit ? ctb_pkg::ONE_HALF : ctb_pkg::ZERO_HALF) + 16'(extra);

  always_comb begin
    res.sample_value = ctb_pkg::VAL_SILENCE;
    res.run_length   = job_r.len;
    res.last_of_run  = 1'b1;
    case (job_r.kind)
      ctb_pkg::KIND_PERIOD: begin
        res.sample_value = phase_r ? ctb_pkg::VAL_LOW : ctb_pkg::VAL_HIGH;
        res.last_of_run  = phase_r;
      end
      ctb_pkg::KIND_BYTE: begin
        res.sample_value = phase_r ? ctb_pkg::VAL_LOW : ctb_pkg::VAL_HIGH;
        res.run_length   = phase_r ? half_r : bit_half;
        res.last_of_run  = phase_r && (bit_r == 3'd7);
      end
      default: begin
        res.sample_value = ctb_pkg::VAL_SILENCE;
      end
    endcase
  end

  always_comb begin
    act_nxt       = act_r;
    job_nxt       = job_r;
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    half_nxt      = half_r;
    drift_nxt     = drift_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (can_emit) begin
      out_valid_nxt = emit;
      if (emit) out_nxt = res;
    end

    if (emit && !done) begin
      phase_nxt = !phase_r;
      if (job_r.kind == ctb_pkg::KIND_BYTE) begin
        if (!phase_r) begin
          half_nxt = bit_half;
          if (job_r.use_drift) begin
            drift_nxt = extra ? (drift_sum - ctb_pkg::DRIFT_LIMIT) : drift_sum;
          end
        end else begin
          bit_nxt          = bit_r + 1'b1;
          job_nxt.byte_val = {job_r.byte_val[6:0], 1'b0};
        end
      end
    end

    if (q_pop) begin
      act_nxt   = 1'b1;
      job_nxt   = head_job;
      phase_nxt = 1'b0;
      bit_nxt   = '0;
      if (head_job.clr_drift) drift_nxt = '0;
    end else if (done) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      phase_r     <= 1'b0;
      bit_r       <= '0;
      drift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      drift_r     <= drift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    half_r <= half_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/cassette_tape_bit_encoder.sv =====
// Top level of the cassette tape bit encoder: front end, job queue, back end.
// Depends on ctb_pkg, ctb_front, ctb_queue and ctb_back.
`default_nettype none

// Turns framing items (leader, sync, data byte, checksum, end tone, silence)
// into square-wave runs at 44.1 kHz, one (sample_value, run_length) item per
// run. The output register delivers one run per clock while out_stall is low.
// A data or checksum item yields 16 runs, a leader/sync/end item 2 runs and a
// silence item 1 run. Items with an unused func code are taken and produce
// nothing. A queue of QUEUE_DEPTH jobs sits between input and output, so the
// input keeps taking items while runs are still streaming out, until the queue
// is full. An accepted item passes through the queue, the back end's job
// register and the output register before its first run appears.
module cassette_tape_bit_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctb_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctb_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata
);

  logic             q_push, q_pop;
  ctb_pkg::job_t    push_job, head_job;
  ctb_pkg::q_stat_t q_stat;

  ctb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  ctb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  ctb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for cassette_tape_bit_encoder: directed items, then random records.
// Depends on ctb_pkg and the encoder RTL under rtl/core.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RATE        = 44100;
  localparam logic [15:0] HALF_LEADER = 16'(RATE / (2 * 770));
  localparam logic [15:0] HALF_SYNC   = 16'(RATE / (2 * 2200));
  localparam logic [15:0] HALF_ONE    = 16'(RATE / (2 * 1000));
  localparam logic [15:0] HALF_ZERO   = 16'(RATE / (2 * 2000));
  localparam logic [15:0] HALF_END    = 16'(RATE / (2 * 200));
  localparam int unsigned DRIFT_WRAP  = 800;
  localparam logic [2:0]  FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_7 = 3'd7;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 30;
  localparam int unsigned LONG_BYTES  = 70;
  localparam int unsigned N_ROWS      = 21;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data;
    logic        typed;   // expected runs written in the row
    logic [15:0] half;
    logic [1:0]  nres;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  ctb_pkg::in_item_t    in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ctb_pkg::out_item_t   out_data;
  logic                 cfg_we = 1'b0;
  logic [15:0]          cfg_wdata = '0;

  // predictor state
  logic [9:0]  tape_drift;
  logic [7:0]  tape_checksum;
  logic [15:0] silence_len;

  ctb_pkg::out_item_t pending_runs[$];
  ctb_pkg::out_item_t fresh_runs[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned runs_checked = 0;
  int unsigned drift_carries = 0;
  bit          quiet = 1'b0;

  row_t directed_rows [0:N_ROWS-1] = '{
    '{ctb_pkg::FUNC_SILENCE,  8'h00, 1'b1, 16'd15000, 2'd1},
    '{ctb_pkg::FUNC_LEADER,   8'hFF, 1'b1, 16'd28,    2'd2},
    '{ctb_pkg::FUNC_SYNC,     8'h00, 1'b1, 16'd10,    2'd2},
    '{ctb_pkg::FUNC_DATA,     8'hFF, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'h00, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'hA5, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'h5A, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'h80, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'h01, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_CHECKSUM, 8'h00, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_END,      8'h55, 1'b1, 16'd110,   2'd2},
    '{FUNC_SPARE_6,           8'hFF, 1'b1, 16'd0,     2'd0},
    '{FUNC_SPARE_7,           8'h00, 1'b1, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_DATA,     8'hC3, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_LEADER,   8'h00, 1'b1, 16'd28,    2'd2},
    '{ctb_pkg::FUNC_CHECKSUM, 8'hFF, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_SYNC,     8'hFF, 1'b1, 16'd10,    2'd2},
    '{ctb_pkg::FUNC_DATA,     8'h7E, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_CHECKSUM, 8'h00, 1'b0, 16'd0,     2'd0},
    '{ctb_pkg::FUNC_END,      8'hAA, 1'b1, 16'd110,   2'd2},
    '{ctb_pkg::FUNC_SILENCE,  8'hFF, 1'b1, 16'd15000, 2'd1}
  };

  cassette_tape_bit_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void add_run(logic [7:0] v, logic [15:0] len, logic last);
    ctb_pkg::out_item_t r;
    r.sample_value = v;
    r.run_length   = len;
    r.last_of_run  = last;
    fresh_runs.push_back(r);
  endfunction

  function automatic void add_period(logic [15:0] half, logic last);
    add_run(ctb_pkg::VAL_HIGH, half, 1'b0);
    add_run(ctb_pkg::VAL_LOW, half, last);
  endfunction

  // MSB first; a carry past the wrap stretches both halves of that bit by one sample
  function automatic void add_byte(logic [7:0] b, inout logic [9:0] drift);
    int unsigned acc;
    logic [15:0] half;
    for (int j = 7; j >= 0; j--) begin
      acc = drift + (b[j] ? 2 : 1);
      half = b[j] ? HALF_ONE : HALF_ZERO;
      if (acc > DRIFT_WRAP) begin
        acc -= DRIFT_WRAP;
        half += 16'd1;
        drift_carries++;
      end
      drift = 10'(acc);
      add_period(half, j == 0);
    end
  endfunction

  function automatic void encode_item(ctb_pkg::in_item_t it);
    logic [9:0] own_drift;
    own_drift = '0;
    fresh_runs.delete();
    case (it.func)
      ctb_pkg::FUNC_LEADER: begin
        tape_checksum = ctb_pkg::CHK_INIT;
        tape_drift = '0;
        add_period(HALF_LEADER, 1'b1);
      end
      ctb_pkg::FUNC_SYNC: add_period(HALF_SYNC, 1'b1);
      ctb_pkg::FUNC_DATA: begin
        tape_checksum ^= it.data_byte;
        add_byte(it.data_byte, tape_drift);
      end
      ctb_pkg::FUNC_CHECKSUM: add_byte(tape_checksum, own_drift);
      ctb_pkg::FUNC_END: add_period(HALF_END, 1'b1);
      ctb_pkg::FUNC_SILENCE: add_run(ctb_pkg::VAL_SILENCE, silence_len, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic ctb_pkg::in_item_t mk(logic [2:0] f, logic [7:0] b);
    ctb_pkg::in_item_t it;
    it.func = f;
    it.data_byte = b;
    return it;
  endfunction

  task automatic send_item(ctb_pkg::in_item_t it, row_t row);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    encode_item(it);
    if (row.typed) begin
      fresh_runs.delete();
      if (row.nres == 2'd1) add_run(ctb_pkg::VAL_SILENCE, row.half, 1'b1);
      else if (row.nres == 2'd2) add_period(row.half, 1'b1);
    end
    foreach (fresh_runs[i]) pending_runs.push_back(fresh_runs[i]);
  endtask

  task automatic send_plain(logic [2:0] f, logic [7:0] b);
    send_item(mk(f, b), '0);
  endtask

  // wait for the last run, then let any spare-code item still in flight clear
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_silence(logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    silence_len = v;
  endtask

  // leader, sync, payload, checksum, end, silence; parts dropped now and then
  task automatic send_record(int unsigned nbytes);
    repeat ($urandom_range(1, 3)) send_plain(ctb_pkg::FUNC_LEADER, 8'($urandom));
    if ($urandom_range(0, 9) != 0) send_plain(ctb_pkg::FUNC_SYNC, 8'($urandom));
    repeat (nbytes) send_plain(ctb_pkg::FUNC_DATA, 8'($urandom));
    if ($urandom_range(0, 9) != 0) send_plain(ctb_pkg::FUNC_CHECKSUM, 8'($urandom));
    if ($urandom_range(0, 9) != 0) send_plain(ctb_pkg::FUNC_END, 8'($urandom));
    if ($urandom_range(0, 1) != 0) send_plain(ctb_pkg::FUNC_SILENCE, 8'($urandom));
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    ctb_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run: value %0d length %0d last %0d",
               out_data.sample_value, out_data.run_length, out_data.last_of_run);
        err_count++;
      end else begin
        want = pending_runs.pop_front();
        runs_checked++;
        if (out_data.sample_value !== want.sample_value) begin
          $error("sample_value: expected %0d, got %0d", want.sample_value,
                 out_data.sample_value);
          err_count++;
        end
        if (out_data.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length,
                 out_data.run_length);
          err_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 out_data.last_of_run);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d runs outstanding", cycle_count,
               pending_runs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [15:0] settings [0:4];
    int unsigned phase_start;
    tape_drift    = '0;
    tape_checksum = ctb_pkg::CHK_INIT;
    silence_len   = ctb_pkg::SILENCE_RESET;
    settings[0] = 16'd0;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(0, 65535));
    settings[3] = 16'd1;
    settings[4] = 16'd15000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_item(mk(directed_rows[i].func, directed_rows[i].data), directed_rows[i]);
    end

    for (int p = 0; p < 5; p++) begin
      write_silence(settings[p]);
      quiet = (p == 2);
      phase_start = items_sent;
      // a long record in two phases so the drift accumulator carries past its wrap
      if (p == 1 || p == 3) send_record(LONG_BYTES);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_record($urandom_range(1, 12));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_plain(3'($urandom_range(0, 7)), 8'($urandom));
          end
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (pending_runs.size() != 0) begin
      $error("%0d expected runs never arrived", pending_runs.size());
      err_count++;
    end
    $display("Sent %0d items (all func codes, five silence lengths incl. 0 and 65535),",
             items_sent);
    $display("checked %0d runs, %0d drift carries seen.", runs_checked, drift_carries);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
